/* rtl/dsc_pkg.sv */
// Shared types, sizes and the control program of the deadlock safety checker.
package dsc_pkg;

  // Table sizes and amount width
  localparam int MAX_PROC    = 16;
  localparam int MAX_RES     = 8;
  localparam int AMOUNT_BITS = 16;

  // Fixed field widths
  localparam int TAG_W   = 16;
  localparam int MODE_W  = 2;
  localparam int PSLOT_W = 4;
  localparam int RSLOT_W = 3;
  localparam int PCFG_W  = 5;
  localparam int RCFG_W  = 4;
  localparam int CFG_W   = 5;

  // Derived sizes
  localparam int PW      = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
  localparam int RW      = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int PCNT_W  = $clog2(MAX_PROC + 1);
  localparam int RCNT_W  = $clog2(MAX_RES + 1);
  localparam int CELLS   = MAX_PROC * MAX_RES;
  localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CELL_W  = 2 * AMOUNT_BITS;
  localparam int AVAIL_W = AMOUNT_BITS + $clog2(MAX_PROC) + 2;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_TOTAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CELL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  // Configuration register indexes
  localparam logic REG_PROC_COUNT = 1'b0;
  localparam logic REG_RES_COUNT  = 1'b1;

  // Program steps
  localparam int STEP_W = 5;
  typedef enum logic [STEP_W-1:0] {
    STEP_IDLE     = 5'd0,
    STEP_AV_START = 5'd1,
    STEP_SUM_RD   = 5'd2,
    STEP_SUM_ACC  = 5'd3,
    STEP_AV_STORE = 5'd4,
    STEP_ROUND    = 5'd5,
    STEP_PROC     = 5'd6,
    STEP_CHK_RD   = 5'd7,
    STEP_CHK      = 5'd8,
    STEP_TEST     = 5'd9,
    STEP_FINISH   = 5'd10,
    STEP_RET_RD   = 5'd11,
    STEP_RET      = 5'd12,
    STEP_ALLCHK   = 5'd13,
    STEP_SAFE     = 5'd14,
    STEP_NEXTP    = 5'd15,
    STEP_DEAD     = 5'd16
  } step_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_TOTAL,
    ACC_SUB_ALLOC
  } acc_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_e;

  typedef enum logic [1:0] {
    FIT_HOLD,
    FIT_SET,
    FIT_CHECK
  } fit_op_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_REPORT,
    EMIT_SAFE,
    EMIT_DEAD
  } emit_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_P_MORE,
    C_R_MORE,
    C_P_FIN,
    C_FIT,
    C_ALL_DONE
  } cond_e;

  // Branch flags from the datapath
  typedef struct packed {
    logic start;
    logic p_more;
    logic r_more;
    logic p_fin;
    logic fit;
    logic all_done;
  } cond_t;

  // One control word
  typedef struct packed {
    logic    take_in;
    logic    clr_run;
    acc_op_e acc_op;
    cnt_op_e p_op;
    cnt_op_e r_op;
    logic    avail_wr;
    logic    avail_add;
    fit_op_e fit_op;
    emit_e   emit;
    cond_e   cond;
    logic    cond_inv;
    step_e   target;
  } ctrl_t;

  // Control program ROM
  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = '{take_in: 1'b0, clr_run: 1'b0, acc_op: ACC_HOLD, p_op: CNT_HOLD,
          r_op: CNT_HOLD, avail_wr: 1'b0, avail_add: 1'b0, fit_op: FIT_HOLD,
          emit: EMIT_NONE, cond: C_ALWAYS, cond_inv: 1'b1, target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        c.take_in  = 1'b1;
        c.clr_run  = 1'b1;
        c.p_op     = CNT_CLEAR;
        c.r_op     = CNT_CLEAR;
        c.cond     = C_START;
        c.cond_inv = 1'b1;
        c.target   = STEP_IDLE;
      end
      STEP_AV_START: begin
        c.acc_op = ACC_LOAD_TOTAL;
        c.p_op   = CNT_CLEAR;
      end
      STEP_SUM_RD: begin
      end
      STEP_SUM_ACC: begin
        c.acc_op   = ACC_SUB_ALLOC;
        c.p_op     = CNT_INC;
        c.cond     = C_P_MORE;
        c.cond_inv = 1'b0;
        c.target   = STEP_SUM_RD;
      end
      STEP_AV_STORE: begin
        c.avail_wr = 1'b1;
        c.r_op     = CNT_INC;
        c.cond     = C_R_MORE;
        c.cond_inv = 1'b0;
        c.target   = STEP_AV_START;
      end
      STEP_ROUND: begin
        c.p_op = CNT_CLEAR;
      end
      STEP_PROC: begin
        c.r_op     = CNT_CLEAR;
        c.fit_op   = FIT_SET;
        c.cond     = C_P_FIN;
        c.cond_inv = 1'b0;
        c.target   = STEP_NEXTP;
      end
      STEP_CHK_RD: begin
      end
      STEP_CHK: begin
        c.fit_op   = FIT_CHECK;
        c.r_op     = CNT_INC;
        c.cond     = C_R_MORE;
        c.cond_inv = 1'b0;
        c.target   = STEP_CHK_RD;
      end
      STEP_TEST: begin
        c.r_op     = CNT_CLEAR;
        c.cond     = C_FIT;
        c.cond_inv = 1'b1;
        c.target   = STEP_NEXTP;
      end
      STEP_FINISH: begin
        c.emit = EMIT_REPORT;
      end
      STEP_RET_RD: begin
      end
      STEP_RET: begin
        c.avail_add = 1'b1;
        c.r_op      = CNT_INC;
        c.cond      = C_R_MORE;
        c.cond_inv  = 1'b0;
        c.target    = STEP_RET_RD;
      end
      STEP_ALLCHK: begin
        c.cond     = C_ALL_DONE;
        c.cond_inv = 1'b1;
        c.target   = STEP_ROUND;
      end
      STEP_SAFE: begin
        c.emit     = EMIT_SAFE;
        c.cond     = C_ALWAYS;
        c.cond_inv = 1'b0;
        c.target   = STEP_IDLE;
      end
      STEP_NEXTP: begin
        c.p_op     = CNT_INC;
        c.cond     = C_P_MORE;
        c.cond_inv = 1'b0;
        c.target   = STEP_PROC;
      end
      STEP_DEAD: begin
        c.emit     = EMIT_DEAD;
        c.cond     = C_ALWAYS;
        c.cond_inv = 1'b0;
        c.target   = STEP_IDLE;
      end
      default: begin
        c.cond     = C_ALWAYS;
        c.cond_inv = 1'b0;
        c.target   = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

/* rtl/deadlock_safety_checker.sv */
// Top level of the deadlock safety checker: tables, datapath and result register.
//
//   channel   direction  handshake             payload
//   in        input      in_valid_i/in_stall_o  mode, process_slot, resource_slot,
//                                              process_tag, demand, held
//   out       output     out_valid_o/out_stall_i is_verdict, finished_tag,
//                                              deadlocked, last
//   cfg       input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// Load beats are accepted back to back while idle.
// A start beat runs the check in the control program: it builds available per
// resource (total less all allocations), then per round scans processes for an
// unfinished one that fits, reports it and returns its allocation; np rounds at
// most, then a verdict. The request/allocation RAM read port sets the pace.
// Reset clears control state only; tables are undefined until loaded.
// A report or verdict step waits while the result register is full and stalled.
module deadlock_safety_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dsc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dsc_pkg::MODE_W-1:0]    mode_i,
  input  logic [dsc_pkg::PSLOT_W-1:0]   process_slot_i,
  input  logic [dsc_pkg::RSLOT_W-1:0]   resource_slot_i,
  input  logic [dsc_pkg::TAG_W-1:0]     process_tag_i,
  input  logic [15:0]                   demand_i,
  input  logic [15:0]                   held_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_verdict_o,
  output logic [dsc_pkg::TAG_W-1:0]     finished_tag_o,
  output logic                          deadlocked_o,
  output logic                          last_o
);

  localparam int A  = dsc_pkg::AMOUNT_BITS;
  localparam int VW = dsc_pkg::AVAIL_W;

  dsc_pkg::ctrl_t ctrl;
  dsc_pkg::cond_t cond;

  // Configuration and control state
  logic [dsc_pkg::PCFG_W-1:0] pc_q;
  logic [dsc_pkg::RCFG_W-1:0] rc_q;
  logic [dsc_pkg::PW-1:0]     p_q;
  logic [dsc_pkg::RW-1:0]     r_q;
  logic [dsc_pkg::PCNT_W-1:0] done_q;
  logic [dsc_pkg::MAX_PROC-1:0] fin_q;
  logic                       fit_q;
  logic                       out_valid_q;

  // Payload state
  logic [A-1:0]               tot_q [dsc_pkg::MAX_RES];
  logic [dsc_pkg::TAG_W-1:0]  tag_q [dsc_pkg::MAX_PROC];
  logic signed [VW-1:0]       avail_q [dsc_pkg::MAX_RES];
  logic signed [VW-1:0]       acc_q;
  logic                       is_verdict_q;
  logic [dsc_pkg::TAG_W-1:0]  tag_out_q;
  logic                       dead_q;

  logic [dsc_pkg::PCNT_W-1:0] np;
  logic [dsc_pkg::RCNT_W-1:0] nr;
  logic                       in_acc;
  logic                       is_start;
  logic                       slot_ok;
  logic                       ram_we;
  logic [dsc_pkg::AW-1:0]     waddr;
  logic [dsc_pkg::AW-1:0]     raddr;
  logic [dsc_pkg::CELL_W-1:0] rdata;
  logic [A-1:0]               cell_req;
  logic [A-1:0]               cell_alloc;
  logic signed [A:0]          need;
  logic signed [VW-1:0]       need_ext;
  logic signed [VW-1:0]       alloc_ext;
  logic                       col_fits;
  logic                       out_free;
  logic                       emitting;
  logic                       hold;
  logic                       go;

  // Clamp the counts into range
  assign np = (pc_q == '0) ? dsc_pkg::PCNT_W'(1) :
              (pc_q > dsc_pkg::MAX_PROC) ? dsc_pkg::PCNT_W'(dsc_pkg::MAX_PROC) :
              dsc_pkg::PCNT_W'(pc_q);
  assign nr = (rc_q == '0) ? dsc_pkg::RCNT_W'(1) :
              (rc_q > dsc_pkg::MAX_RES) ? dsc_pkg::RCNT_W'(dsc_pkg::MAX_RES) :
              dsc_pkg::RCNT_W'(rc_q);

  // Input handshake: beats land only while the program idles
  assign in_stall_o = !ctrl.take_in;
  assign in_acc     = in_valid_i && ctrl.take_in;
  assign is_start   = in_acc && (mode_i == dsc_pkg::MODE_START);
  assign slot_ok    = (process_slot_i < dsc_pkg::MAX_PROC) &&
                      (resource_slot_i < dsc_pkg::MAX_RES);
  assign ram_we     = in_acc && (mode_i == dsc_pkg::MODE_CELL) && slot_ok;
  assign waddr      = dsc_pkg::AW'(process_slot_i) * dsc_pkg::AW'(dsc_pkg::MAX_RES)
                      + dsc_pkg::AW'(resource_slot_i);
  assign raddr      = dsc_pkg::AW'(p_q) * dsc_pkg::AW'(dsc_pkg::MAX_RES)
                      + dsc_pkg::AW'(r_q);

  // Request and allocation cells, one RAM word per cell
  dsc_ram #(
    .WIDTH(dsc_pkg::CELL_W),
    .DEPTH(dsc_pkg::CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({A'(demand_i), A'(held_i)}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Need against available for the current column
  assign cell_req   = rdata[dsc_pkg::CELL_W-1:A];
  assign cell_alloc = rdata[A-1:0];
  assign need       = $signed({1'b0, cell_req}) - $signed({1'b0, cell_alloc});
  assign need_ext   = VW'(need);
  assign alloc_ext  = $signed(VW'(cell_alloc));
  assign col_fits   = need_ext <= avail_q[r_q];

  // Branch flags
  assign cond.start    = is_start;
  assign cond.p_more   = (dsc_pkg::PCNT_W'(p_q) + dsc_pkg::PCNT_W'(1)) < np;
  assign cond.r_more   = (dsc_pkg::RCNT_W'(r_q) + dsc_pkg::RCNT_W'(1)) < nr;
  assign cond.p_fin    = fin_q[p_q];
  assign cond.fit      = fit_q;
  assign cond.all_done = done_q == np;

  // Freeze the program while a result waits for room
  assign out_free = !out_valid_q || !out_stall_i;
  assign emitting = ctrl.emit != dsc_pkg::EMIT_NONE;
  assign hold     = emitting && !out_free;
  assign go       = !hold;

  dsc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hold_i (hold),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  // Control state: counts, counters, flags, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= dsc_pkg::PCFG_W'(1);
      rc_q        <= dsc_pkg::RCFG_W'(1);
      p_q         <= '0;
      r_q         <= '0;
      done_q      <= '0;
      fin_q       <= '0;
      fit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dsc_pkg::REG_PROC_COUNT: pc_q <= cfg_data_i[dsc_pkg::PCFG_W-1:0];
          dsc_pkg::REG_RES_COUNT:  rc_q <= cfg_data_i[dsc_pkg::RCFG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (go) begin
        if (ctrl.clr_run) begin
          done_q <= '0;
          fin_q  <= '0;
        end
        case (ctrl.p_op)
          dsc_pkg::CNT_CLEAR: p_q <= '0;
          dsc_pkg::CNT_INC:   p_q <= p_q + dsc_pkg::PW'(1);
          default: ;
        endcase
        case (ctrl.r_op)
          dsc_pkg::CNT_CLEAR: r_q <= '0;
          dsc_pkg::CNT_INC:   r_q <= r_q + dsc_pkg::RW'(1);
          default: ;
        endcase
        case (ctrl.fit_op)
          dsc_pkg::FIT_SET:   fit_q <= 1'b1;
          dsc_pkg::FIT_CHECK: fit_q <= fit_q && col_fits;
          default: ;
        endcase
        if (ctrl.emit == dsc_pkg::EMIT_REPORT) begin
          fin_q[p_q] <= 1'b1;
          done_q     <= done_q + dsc_pkg::PCNT_W'(1);
        end
        if (emitting) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  // Payload: tables, accumulator, available, result fields
  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == dsc_pkg::MODE_TOTAL) &&
        (resource_slot_i < dsc_pkg::MAX_RES)) begin
      tot_q[dsc_pkg::RW'(resource_slot_i)] <= A'(demand_i);
    end
    if (ram_we) begin
      tag_q[dsc_pkg::PW'(process_slot_i)] <= process_tag_i;
    end
    if (go) begin
      case (ctrl.acc_op)
        dsc_pkg::ACC_LOAD_TOTAL: acc_q <= $signed(VW'(tot_q[r_q]));
        dsc_pkg::ACC_SUB_ALLOC:  acc_q <= acc_q - alloc_ext;
        default: ;
      endcase
      if (ctrl.avail_wr) begin
        avail_q[r_q] <= acc_q;
      end else if (ctrl.avail_add) begin
        avail_q[r_q] <= avail_q[r_q] + alloc_ext;
      end
      case (ctrl.emit)
        dsc_pkg::EMIT_REPORT: begin
          is_verdict_q <= 1'b0;
          tag_out_q    <= tag_q[p_q];
          dead_q       <= 1'b0;
        end
        dsc_pkg::EMIT_SAFE: begin
          is_verdict_q <= 1'b1;
          tag_out_q    <= '0;
          dead_q       <= 1'b0;
        end
        dsc_pkg::EMIT_DEAD: begin
          is_verdict_q <= 1'b1;
          tag_out_q    <= '0;
          dead_q       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Drive the result beat
  assign out_valid_o    = out_valid_q;
  assign is_verdict_o   = is_verdict_q;
  assign finished_tag_o = tag_out_q;
  assign deadlocked_o   = dead_q;
  assign last_o         = is_verdict_q;

endmodule

/* rtl/dsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, and register the read data; a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/dsc_seq.sv */
// Step counter and control ROM that drive the safety check datapath.
module dsc_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          hold_i,
  input  dsc_pkg::cond_t cond_i,
  output dsc_pkg::ctrl_t ctrl_o
);

  dsc_pkg::step_e step_q, step_d;
  logic           sel;

  // Look up the control word of this step
  assign ctrl_o = dsc_pkg::ucode(step_q);

  // Pick the branch flag
  always_comb begin
    case (ctrl_o.cond)
      dsc_pkg::C_ALWAYS:   sel = 1'b1;
      dsc_pkg::C_START:    sel = cond_i.start;
      dsc_pkg::C_P_MORE:   sel = cond_i.p_more;
      dsc_pkg::C_R_MORE:   sel = cond_i.r_more;
      dsc_pkg::C_P_FIN:    sel = cond_i.p_fin;
      dsc_pkg::C_FIT:      sel = cond_i.fit;
      dsc_pkg::C_ALL_DONE: sel = cond_i.all_done;
      default:             sel = 1'b0;
    endcase
  end

  // Hold, jump or advance
  always_comb begin
    if (hold_i) begin
      step_d = step_q;
    end else if (sel ^ ctrl_o.cond_inv) begin
      step_d = ctrl_o.target;
    end else begin
      step_d = dsc_pkg::step_e'(step_q + 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= dsc_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
